>>> rtl/tgc_pkg.sv
// Shared types, constants and state codes for the greedy crossover unit.
package tgc_pkg;

    // Defaults for the top level parameters
    localparam int MAX_CITIES_DEF  = 64;
    localparam int COORD_BITS_DEF  = 16;

    // Fixed field widths
    localparam int CITY_W      = 6;
    localparam int CC_W        = 7;
    localparam int RAW_COORD_W = 16;
    localparam int SEED_W      = 32;
    localparam int DIST_W      = 64;

    // Galois LFSR feedback mask for the random fill
    localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    // Opcodes of the input item
    localparam logic [1:0] OP_LOAD_XY  = 2'd0;
    localparam logic [1:0] OP_LOAD_PAR = 2'd1;
    localparam logic [1:0] OP_START    = 2'd2;

    typedef struct packed {
        logic [1:0]                    op;
        logic [CITY_W-1:0]             position;
        logic signed [RAW_COORD_W-1:0] coord_x;
        logic signed [RAW_COORD_W-1:0] coord_y;
        logic [CITY_W-1:0]             first_city;
        logic [CITY_W-1:0]             second_city;
        logic                          take_first_parent;
        logic [CITY_W-1:0]             swap_a;
        logic [CITY_W-1:0]             swap_b;
        logic [SEED_W-1:0]             seed;
    } in_item_t;

    typedef struct packed {
        logic [CITY_W-1:0] city;
        logic [CITY_W-1:0] tour_pos;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_XY,
        CMD_PAR,
        CMD_START
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                     kind;
        logic [CITY_W-1:0]             pos;
        logic signed [RAW_COORD_W-1:0] cx;
        logic signed [RAW_COORD_W-1:0] cy;
        logic [CITY_W-1:0]             c1;
        logic [CITY_W-1:0]             c2;
        logic                          take;
        logic [CITY_W-1:0]             sa;
        logic [CITY_W-1:0]             sb;
        logic [SEED_W-1:0]             seed;
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_C0_RD,
        ST_C0_SEL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIST_RD,
        ST_DIST_DIFF,
        ST_DIST_SQ,
        ST_DIST_SUM,
        ST_RAND_STEP,
        ST_RAND_MOD,
        ST_RAND_SCAN,
        ST_SWAP_RD,
        ST_SWAP_WA,
        ST_SWAP_WB,
        ST_ZERO_RD,
        ST_ZERO_CHK,
        ST_ENDS_RD,
        ST_ENDS_CHK,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    // One step of the fill LFSR
    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] r;
        r = s >> 1;
        if (s[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

>>> rtl/tsp_greedy_crossover_unit.sv
// Top level of the greedy crossover unit: city count register and front/back halves.
//
// Loads of a coordinate or of a pair of parent entries are written in the idle state
// of the back sequencer after a short command queue. A start item builds the child
// tour: each parent probe reads both parent tours (one read port per parent tour), a
// distance comparison reads, subtracts, squares and sums for each candidate, and each
// random fill pick forms a one-bit-per-cycle remainder and then scans the visited
// flags. The tour then goes through an optional swap, a search for city 0 and the
// emission of each city in turn. A start is carried out by the single sequencer and
// its memory ports. Results wait in an output register while new items are still
// taken into the queue.
module tsp_greedy_crossover_unit
    import tgc_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  in_item_t        in_item,
    output logic            empty,
    input  logic            pop,
    output out_item_t       out_item,
    input  logic            cfg_we,
    input  logic [CC_W-1:0] cfg_data
);

    logic [CC_W-1:0] city_count_reg;
    logic            cmd_valid;
    logic            cmd_pop;
    cmd_t            cmd;

    // Hold the city count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= CC_W'(64);
        end
        else if (cfg_we)
        begin
            city_count_reg <= cfg_data;
        end
    end

    tgc_front #(
        .MAX_CITIES (MAX_CITIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tgc_back #(
        .MAX_CITIES (MAX_CITIES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .city_count (city_count_reg),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item)
    );

endmodule

>>> rtl/tgc_front.sv
// Front end: accepts input items, drops the ones without effect, queues commands.
module tgc_front
    import tgc_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    cmd_t                q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                accept;
    logic                keep;
    logic                pos_ok;
    logic                do_wr;
    logic                do_rd;
    cmd_t                new_cmd;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign accept    = push && !full;

    // Classify the item and build the command
    always_comb
    begin
        pos_ok = (int'(in_item.position) < MAX_CITIES);
        keep   = 1'b0;
        new_cmd.kind = CMD_START;
        unique case (in_item.op)
            OP_LOAD_XY:
            begin
                keep         = pos_ok;
                new_cmd.kind = CMD_XY;
            end
            OP_LOAD_PAR:
            begin
                keep         = pos_ok;
                new_cmd.kind = CMD_PAR;
            end
            OP_START:
            begin
                keep         = 1'b1;
                new_cmd.kind = CMD_START;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        new_cmd.pos  = in_item.position;
        new_cmd.cx   = in_item.coord_x;
        new_cmd.cy   = in_item.coord_y;
        new_cmd.c1   = in_item.first_city;
        new_cmd.c2   = in_item.second_city;
        new_cmd.take = in_item.take_first_parent;
        new_cmd.sa   = in_item.swap_a;
        new_cmd.sb   = in_item.swap_b;
        new_cmd.seed = in_item.seed;
    end

    assign do_wr = accept && keep;
    assign do_rd = cmd_pop && cmd_valid;

    // Store queue entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0
                              : wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0
                              : rd_ptr_reg + QUEUE_AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end
            else if (!do_wr && do_rd)
            begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

>>> rtl/tgc_back.sv
// Back end: coordinate and tour memories, crossover sequencer and result register.
module tgc_back
    import tgc_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  cmd_t            cmd,
    output logic            cmd_pop,
    input  logic [CC_W-1:0] city_count,
    output logic            empty,
    input  logic            pop,
    output out_item_t       out_item
);

    localparam int AW   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int CW   = $clog2(MAX_CITIES + 1);
    localparam int DW   = COORD_BITS + 1;
    localparam int SQ_W = 2 * DW;

    // Memories
    logic [COORD_BITS-1:0] x_mem [MAX_CITIES];
    logic [COORD_BITS-1:0] y_mem [MAX_CITIES];
    logic [CITY_W-1:0]     p1_mem [MAX_CITIES];
    logic [CITY_W-1:0]     p2_mem [MAX_CITIES];
    logic [CITY_W-1:0]     ch_mem [MAX_CITIES];

    logic [COORD_BITS-1:0] xq0_reg, xq1_reg, yq0_reg, yq1_reg;
    logic [CITY_W-1:0]     p1q_reg, p2q_reg, cq0_reg, cq1_reg;

    state_t state_reg, state_next;

    logic [CW-1:0]     n_reg, i_reg, ptr1_reg, ptr2_reg, left_reg;
    logic [CW-1:0]     j_reg, seen_reg, k_reg, rem_reg;
    logic [CITY_W-1:0] prev_reg, cand_a_reg, cand_b_reg, sa_reg, sb_reg, held_reg;
    logic              sel_b_reg, take_reg, rev_reg;
    logic [DW-1:0]     dx_reg, dy_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg;
    logic [DIST_W-1:0] da_reg;
    logic [SEED_W-1:0] lfsr_reg, modv_reg;
    logic [4:0]        bit_reg;
    logic [MAX_CITIES-1:0] vis_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;

    // Combinational controls
    logic [CW-1:0]     n_cfg;
    logic              f1, f2, done1, done2;
    logic              i_last, commit_en, swap_ok, out_load;
    logic [CITY_W-1:0] commit_city, c0_raw;
    logic [SQ_W:0]     dsum;
    logic [DIST_W-1:0] dist_cur;
    logic [CW:0]       rem_t;
    logic [CW-1:0]     rem_new;
    logic [CW:0]       s1_t, sl_t, src_t;
    logic [CW-1:0]     src_m, s1, sl, src;
    logic              j_free;
    logic [AW-1:0]     p1_addr, p2_addr, xa0, xa1, ca0, ca1, ch_wa;
    logic [CITY_W-1:0] ch_wd;
    logic              ch_we;
    logic signed [31:0]   x_ext, y_ext;
    logic signed [DW-1:0] xdiff, ydiff;

    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    // Clamp the configured city count
    always_comb
    begin
        if (int'(city_count) < 2)
        begin
            n_cfg = CW'(2);
        end
        else if (int'(city_count) > MAX_CITIES)
        begin
            n_cfg = CW'(MAX_CITIES);
        end
        else
        begin
            n_cfg = CW'(city_count);
        end
    end

    // Datapath decisions
    always_comb
    begin
        f1    = (ptr1_reg < n_reg) && (p1q_reg < n_reg) && !vis_reg[AW'(p1q_reg)];
        f2    = (ptr2_reg < n_reg) && (p2q_reg < n_reg) && !vis_reg[AW'(p2q_reg)];
        done1 = (ptr1_reg >= n_reg) || f1;
        done2 = (ptr2_reg >= n_reg) || f2;
        i_last = ((i_reg + CW'(1)) == n_reg);
        swap_ok = (sa_reg != sb_reg) && (sa_reg < n_reg) && (sb_reg < n_reg);

        dsum     = {1'b0, sx_reg} + {1'b0, sy_reg};
        dist_cur = ((dsum >> DIST_W) != '0) ? '1 : DIST_W'(dsum);

        rem_t = {rem_reg, modv_reg[SEED_W-1]};
        if (rem_t >= {1'b0, left_reg})
        begin
            rem_t = rem_t - {1'b0, left_reg};
        end
        rem_new = CW'(rem_t);

        j_free = (j_reg < n_reg) && !vis_reg[AW'(j_reg)];

        s1_t = {1'b0, k_reg} + (CW+1)'(1);
        if (s1_t >= {1'b0, n_reg})
        begin
            s1_t = s1_t - {1'b0, n_reg};
        end
        s1 = CW'(s1_t);
        sl_t = {1'b0, k_reg} + {1'b0, n_reg} - (CW+1)'(1);
        if (sl_t >= {1'b0, n_reg})
        begin
            sl_t = sl_t - {1'b0, n_reg};
        end
        sl = CW'(sl_t);

        src_m = (rev_reg && (j_reg != '0)) ? (n_reg - j_reg) : j_reg;
        src_t = {1'b0, k_reg} + {1'b0, src_m};
        if (src_t >= {1'b0, n_reg})
        begin
            src_t = src_t - {1'b0, n_reg};
        end
        src = CW'(src_t);

        c0_raw = take_reg ? p1q_reg : p2q_reg;

        commit_en   = 1'b0;
        commit_city = '0;
        unique case (state_reg)
            ST_C0_SEL:
            begin
                commit_en   = 1'b1;
                commit_city = (c0_raw < n_reg) ? c0_raw : '0;
            end
            ST_SCAN_CHK:
            begin
                if (done1 && done2 && (f1 != f2))
                begin
                    commit_en   = 1'b1;
                    commit_city = f1 ? p1q_reg : p2q_reg;
                end
            end
            ST_DIST_SUM:
            begin
                if (sel_b_reg)
                begin
                    commit_en   = 1'b1;
                    commit_city = (da_reg < dist_cur) ? cand_a_reg : cand_b_reg;
                end
            end
            ST_RAND_SCAN:
            begin
                if (j_reg >= n_reg)
                begin
                    commit_en   = 1'b1;
                    commit_city = '0;
                end
                else if (j_free && (seen_reg == rem_reg))
                begin
                    commit_en   = 1'b1;
                    commit_city = CITY_W'(j_reg);
                end
            end
            default:
            begin
                commit_en = 1'b0;
            end
        endcase

        out_load = (state_reg == ST_EMIT_OUT) && (!out_valid_reg || pop);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.kind == CMD_START))
                begin
                    state_next = ST_C0_RD;
                end
            end
            ST_C0_RD:     state_next = ST_C0_SEL;
            ST_C0_SEL:    state_next = i_last ? ST_SWAP_RD : ST_SCAN_RD;
            ST_SCAN_RD:   state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (!(done1 && done2))
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (f1 && f2)
                begin
                    state_next = ST_DIST_RD;
                end
                else if (!f1 && !f2)
                begin
                    state_next = ST_RAND_STEP;
                end
                else
                begin
                    state_next = i_last ? ST_SWAP_RD : ST_SCAN_RD;
                end
            end
            ST_DIST_RD:   state_next = ST_DIST_DIFF;
            ST_DIST_DIFF: state_next = ST_DIST_SQ;
            ST_DIST_SQ:   state_next = ST_DIST_SUM;
            ST_DIST_SUM:
            begin
                if (!sel_b_reg)
                begin
                    state_next = ST_DIST_RD;
                end
                else
                begin
                    state_next = i_last ? ST_SWAP_RD : ST_SCAN_RD;
                end
            end
            ST_RAND_STEP: state_next = ST_RAND_MOD;
            ST_RAND_MOD:
            begin
                if (bit_reg == '0)
                begin
                    state_next = ST_RAND_SCAN;
                end
            end
            ST_RAND_SCAN:
            begin
                if (commit_en)
                begin
                    state_next = i_last ? ST_SWAP_RD : ST_RAND_STEP;
                end
            end
            ST_SWAP_RD:   state_next = swap_ok ? ST_SWAP_WA : ST_ZERO_RD;
            ST_SWAP_WA:   state_next = ST_SWAP_WB;
            ST_SWAP_WB:   state_next = ST_ZERO_RD;
            ST_ZERO_RD:   state_next = ST_ZERO_CHK;
            ST_ZERO_CHK:
            begin
                if ((cq0_reg == '0) || ((k_reg + CW'(1)) >= n_reg))
                begin
                    state_next = ST_ENDS_RD;
                end
                else
                begin
                    state_next = ST_ZERO_RD;
                end
            end
            ST_ENDS_RD:   state_next = ST_ENDS_CHK;
            ST_ENDS_CHK:  state_next = ST_EMIT_RD;
            ST_EMIT_RD:   state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
            begin
                if (out_load)
                begin
                    state_next = ((j_reg + CW'(1)) == n_reg) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory addresses and write strobes
    always_comb
    begin
        p1_addr = AW'(ptr1_reg);
        p2_addr = AW'(ptr2_reg);
        xa0     = sel_b_reg ? AW'(cand_b_reg) : AW'(cand_a_reg);
        xa1     = AW'(prev_reg);
        ca0     = AW'(src);
        ca1     = AW'(sl);
        ch_we   = commit_en;
        ch_wa   = AW'(i_reg);
        ch_wd   = commit_city;
        unique case (state_reg)
            ST_C0_RD:
            begin
                p1_addr = '0;
                p2_addr = '0;
            end
            ST_SWAP_RD, ST_SWAP_WA, ST_SWAP_WB:
            begin
                ca0 = AW'(sa_reg);
                ca1 = AW'(sb_reg);
                if (state_reg == ST_SWAP_WA)
                begin
                    ch_we = 1'b1;
                    ch_wa = AW'(sa_reg);
                    ch_wd = cq1_reg;
                end
                else if (state_reg == ST_SWAP_WB)
                begin
                    ch_we = 1'b1;
                    ch_wa = AW'(sb_reg);
                    ch_wd = held_reg;
                end
            end
            ST_ZERO_RD, ST_ZERO_CHK:
            begin
                ca0 = AW'(k_reg);
            end
            ST_ENDS_RD, ST_ENDS_CHK:
            begin
                ca0 = AW'(s1);
                ca1 = AW'(sl);
            end
            default:
            begin
                ca0 = AW'(src);
            end
        endcase
    end

    // Coordinates sign-extended from the raw input width, stored at the coordinate width
    assign x_ext = 32'(cmd.cx);
    assign y_ext = 32'(cmd.cy);

    // Memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd_pop && (cmd.kind == CMD_XY))
        begin
            x_mem[AW'(cmd.pos)] <= x_ext[COORD_BITS-1:0];
            y_mem[AW'(cmd.pos)] <= y_ext[COORD_BITS-1:0];
        end
        if (cmd_pop && (cmd.kind == CMD_PAR))
        begin
            p1_mem[AW'(cmd.pos)] <= cmd.c1;
            p2_mem[AW'(cmd.pos)] <= cmd.c2;
        end
        if (ch_we)
        begin
            ch_mem[ch_wa] <= ch_wd;
        end
        p1q_reg <= p1_mem[p1_addr];
        p2q_reg <= p2_mem[p2_addr];
        xq0_reg <= x_mem[xa0];
        xq1_reg <= x_mem[xa1];
        yq0_reg <= y_mem[xa0];
        yq1_reg <= y_mem[xa1];
        cq0_reg <= ch_mem[ca0];
        cq1_reg <= ch_mem[ca1];
    end

    // Distance arithmetic
    always_comb
    begin
        xdiff = DW'($signed(xq0_reg)) - DW'($signed(xq1_reg));
        ydiff = DW'($signed(yq0_reg)) - DW'($signed(yq1_reg));
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIST_DIFF)
        begin
            dx_reg <= xdiff[DW-1] ? DW'(-xdiff) : DW'(xdiff);
            dy_reg <= ydiff[DW-1] ? DW'(-ydiff) : DW'(ydiff);
        end
        if (state_reg == ST_DIST_SQ)
        begin
            sx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            sy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        end
        if ((state_reg == ST_DIST_SUM) && !sel_b_reg)
        begin
            da_reg <= dist_cur;
        end
        if (state_reg == ST_SWAP_WA)
        begin
            held_reg <= cq0_reg;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            ptr1_reg      <= '0;
            ptr2_reg      <= '0;
            left_reg      <= '0;
            j_reg         <= '0;
            seen_reg      <= '0;
            k_reg         <= '0;
            rem_reg       <= '0;
            prev_reg      <= '0;
            cand_a_reg    <= '0;
            cand_b_reg    <= '0;
            sa_reg        <= '0;
            sb_reg        <= '0;
            sel_b_reg     <= 1'b0;
            take_reg      <= 1'b0;
            rev_reg       <= 1'b0;
            lfsr_reg      <= SEED_W'(1);
            modv_reg      <= '0;
            bit_reg       <= '0;
            vis_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Latch a start
            if (cmd_pop && (cmd.kind == CMD_START))
            begin
                n_reg    <= n_cfg;
                i_reg    <= '0;
                ptr1_reg <= '0;
                ptr2_reg <= '0;
                take_reg <= cmd.take;
                sa_reg   <= cmd.sa;
                sb_reg   <= cmd.sb;
                lfsr_reg <= (cmd.seed == '0) ? SEED_W'(1) : cmd.seed;
                vis_reg  <= '0;
                sel_b_reg <= 1'b0;
            end

            // Place a city in the child tour
            if (commit_en)
            begin
                vis_reg[AW'(commit_city)] <= 1'b1;
                prev_reg <= commit_city;
                i_reg    <= i_reg + CW'(1);
                left_reg <= left_reg - CW'(1);
                ptr1_reg <= (ptr1_reg < (i_reg + CW'(1))) ? (i_reg + CW'(1)) : ptr1_reg;
                ptr2_reg <= (ptr2_reg < (i_reg + CW'(1))) ? (i_reg + CW'(1)) : ptr2_reg;
                sel_b_reg <= 1'b0;
            end

            // Advance the parent scans
            if ((state_reg == ST_SCAN_CHK) && !(done1 && done2))
            begin
                if (!done1)
                begin
                    ptr1_reg <= ptr1_reg + CW'(1);
                end
                if (!done2)
                begin
                    ptr2_reg <= ptr2_reg + CW'(1);
                end
            end
            if ((state_reg == ST_SCAN_CHK) && done1 && done2)
            begin
                cand_a_reg <= p1q_reg;
                cand_b_reg <= p2q_reg;
                if (!commit_en)
                begin
                    left_reg <= n_reg - i_reg;
                end
            end
            if ((state_reg == ST_DIST_SUM) && !sel_b_reg)
            begin
                sel_b_reg <= 1'b1;
            end

            // Random fill: step, reduce, then count free cities
            if (state_reg == ST_RAND_STEP)
            begin
                lfsr_reg <= lfsr_step(lfsr_reg);
                modv_reg <= lfsr_step(lfsr_reg);
                rem_reg  <= '0;
                bit_reg  <= 5'(SEED_W - 1);
            end
            if (state_reg == ST_RAND_MOD)
            begin
                rem_reg  <= rem_new;
                modv_reg <= modv_reg << 1;
                bit_reg  <= bit_reg - 5'd1;
                j_reg    <= '0;
                seen_reg <= '0;
            end
            if ((state_reg == ST_RAND_SCAN) && !commit_en)
            begin
                j_reg <= j_reg + CW'(1);
                if (j_free)
                begin
                    seen_reg <= seen_reg + CW'(1);
                end
            end

            // Find city 0 and the direction
            if (state_reg == ST_SWAP_RD)
            begin
                k_reg <= '0;
            end
            if (state_reg == ST_ZERO_CHK)
            begin
                if (cq0_reg != '0)
                begin
                    k_reg <= ((k_reg + CW'(1)) >= n_reg) ? '0 : k_reg + CW'(1);
                end
            end
            if (state_reg == ST_ENDS_CHK)
            begin
                rev_reg <= (cq1_reg > cq0_reg);
                j_reg   <= '0;
            end

            // Result register
            if (out_load)
            begin
                out_reg.city     <= cq0_reg;
                out_reg.tour_pos <= CITY_W'(j_reg);
                out_reg.last     <= ((j_reg + CW'(1)) == n_reg);
                out_valid_reg    <= 1'b1;
                j_reg            <= j_reg + CW'(1);
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
